// ===== src/dtpd_pkg.sv =====
// ----------------------------------------------------------------------------
// Dimmer package
// Shared types, codes and fixed widths of the table-driven PWM dimmer.
// ----------------------------------------------------------------------------
package dtpd_pkg;

   // Request kinds carried on the request channel's tuser.
   typedef enum logic [2:0] {
      REQ_TICK  = 3'd0,
      REQ_START = 3'd1,
      REQ_DUTY  = 3'd2,
      REQ_REARM = 3'd3,
      REQ_STOP  = 3'd4
   } req_kind_type;

   // Run status as reported in every response.
   typedef enum logic [1:0] {
      STATUS_IDLE    = 2'd0,
      STATUS_RUNNING = 2'd1,
      STATUS_REFUSED = 2'd2
   } status_type;

   // Configuration register indexes.
   localparam logic CSR_PERIOD = 1'b0;
   localparam logic CSR_KHZ    = 1'b1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 20;
   localparam int PERIOD_W    = 20;
   localparam int KHZ_W       = 18;
   localparam int PRODUCT_W   = PERIOD_W + KHZ_W;
   localparam int RELOAD_W    = 32;
   localparam int DUTY_W      = 7;
   localparam int DUTY_MAX    = 100;
   localparam int POS_W       = 7;
   localparam int REARM_W     = 16;

   typedef struct packed {
      logic               light_on;
      status_type         status_code;
      logic [POS_W-1:0]   word_position;
      logic               channel_idle;
      logic [REARM_W-1:0] rearm_total;
   } result_type;

endpackage

// ===== src/dtpd_reload.sv =====
// ----------------------------------------------------------------------------
// Reload calculator
// Holds the configuration registers and derives the timer reload value from
// them with one multiply and a multiplication by the reciprocal of the fixed
// divisor, taken in 16-bit slices.
// ----------------------------------------------------------------------------
module dtpd_reload #(
   parameter int WAVE_WORDS    = 100,
   parameter int MIN_CLOCK_KHZ = 100
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [dtpd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dtpd_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                busy,
   output logic                                clock_low,
   output logic [dtpd_pkg::RELOAD_W-1:0]       reload
);

   localparam int PW      = dtpd_pkg::PRODUCT_W;
   localparam int DIVISOR = 1000 * WAVE_WORDS;
   localparam int DW      = $clog2(DIVISOR + 1);
   // The product stays below 2^PW and the divisor below 2^DW, so a reciprocal
   // rounded up with PW + DW fraction bits gives the exact quotient.
   localparam int RECIP_K = PW + DW;
   localparam logic [63:0] RECIP = ((64'd1 << RECIP_K) + 64'(DIVISOR) - 64'd1)
                                   / 64'(DIVISOR);
   localparam int CHUNK_W = 16;
   localparam int CHUNKS  = 3;
   localparam int MW      = CHUNK_W * CHUNKS;
   localparam int ACC_W   = PW + CHUNK_W;
   localparam int QSHIFT  = RECIP_K - CHUNK_W * (CHUNKS - 1);
   localparam int CNTW    = $clog2(CHUNKS);

   typedef enum logic [1:0] {
      PH_MUL,
      PH_MAC,
      PH_FIN,
      PH_DONE
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic [dtpd_pkg::PERIOD_W-1:0]     period_ff, period_in;
   logic [dtpd_pkg::KHZ_W-1:0]        khz_ff, khz_in;
   logic [PW-1:0]                     prod_ff, prod_in;
   logic [MW-1:0]                     mult_ff, mult_in;
   logic [ACC_W-1:0]                  acc_ff, acc_in;
   logic [CNTW-1:0]                   count_ff, count_in;
   logic [dtpd_pkg::RELOAD_W-1:0]     reload_ff, reload_in;
   logic [ACC_W-1:0]                  partial;
   logic [ACC_W-1:0]                  quot;

   // One slice of the reciprocal times the product. The accumulator is
   // shifted down by a slice each step, which keeps the floor exact.
   assign partial = {{CHUNK_W{1'b0}}, prod_ff} * {{PW{1'b0}}, mult_ff[CHUNK_W-1:0]};
   assign quot    = acc_ff >> QSHIFT;

   always_comb begin
      phase_in  = phase_ff;
      period_in = period_ff;
      khz_in    = khz_ff;
      prod_in   = prod_ff;
      mult_in   = mult_ff;
      acc_in    = acc_ff;
      count_in  = count_ff;
      reload_in = reload_ff;
      unique case (phase_ff)
         PH_MUL: begin
            prod_in  = {{(PW - dtpd_pkg::KHZ_W){1'b0}}, khz_ff}
                     * {{(PW - dtpd_pkg::PERIOD_W){1'b0}}, period_ff};
            mult_in  = RECIP[MW-1:0];
            acc_in   = '0;
            count_in = CNTW'(CHUNKS - 1);
            phase_in = PH_MAC;
         end
         PH_MAC: begin
            acc_in  = (acc_ff >> CHUNK_W) + partial;
            mult_in = mult_ff >> CHUNK_W;
            if (count_ff == '0) begin
               phase_in = PH_FIN;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         PH_FIN: begin
            // A zero quotient would give an all-ones reload, so it is forced to one.
            reload_in = (quot != '0) ? dtpd_pkg::RELOAD_W'(quot - 1'b1)
                                     : dtpd_pkg::RELOAD_W'(1);
            phase_in  = PH_DONE;
         end
         default: begin
         end
      endcase
      if (csr_we) begin
         if (csr_index == dtpd_pkg::CSR_PERIOD) begin
            period_in = csr_wdata[dtpd_pkg::PERIOD_W-1:0];
         end else begin
            khz_in = csr_wdata[dtpd_pkg::KHZ_W-1:0];
         end
         phase_in = PH_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MUL;
         period_ff <= dtpd_pkg::PERIOD_W'(4000);
         khz_ff    <= '0;
         reload_ff <= '0;
      end else begin
         phase_ff  <= phase_in;
         period_ff <= period_in;
         khz_ff    <= khz_in;
         reload_ff <= reload_in;
      end
      prod_ff  <= prod_in;
      mult_ff  <= mult_in;
      acc_ff   <= acc_in;
      count_ff <= count_in;
   end

   assign busy      = (phase_ff != PH_DONE);
   assign clock_low = (khz_ff < dtpd_pkg::KHZ_W'(MIN_CLOCK_KHZ));
   assign reload    = reload_ff;

endmodule

// ===== src/dtpd_engine.sv =====
// ----------------------------------------------------------------------------
// Dimmer engine
// Timer, word pointer and block repeat state, updated once per request.
// ----------------------------------------------------------------------------
module dtpd_engine #(
   parameter int WAVE_WORDS    = 100,
   parameter int BLOCK_REPEATS = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic [2:0]                       req_kind,
   input  logic [7:0]                       duty_raw,
   input  logic [dtpd_pkg::RELOAD_W-1:0]    reload,
   input  logic                             clock_low,
   output dtpd_pkg::result_type             result
);

   localparam int IW = (WAVE_WORDS > 1) ? $clog2(WAVE_WORDS) : 1;
   localparam int RW = $clog2(BLOCK_REPEATS + 1);
   localparam int CW = $clog2(dtpd_pkg::DUTY_MAX * WAVE_WORDS + 1);

   dtpd_pkg::status_type              run_ff, run_in;
   logic [dtpd_pkg::DUTY_W-1:0]       duty_ff, duty_in;
   logic [dtpd_pkg::RELOAD_W-1:0]     reload_ff, reload_in;
   logic [dtpd_pkg::RELOAD_W-1:0]     tick_ff, tick_in;
   logic [IW-1:0]                     index_ff, index_in;
   logic [RW-1:0]                     repeats_ff, repeats_in;
   logic                              dma_idle_ff, dma_idle_in;
   logic                              pin_ff, pin_in;
   logic [dtpd_pkg::REARM_W-1:0]      rearm_ff, rearm_in;
   logic [dtpd_pkg::DUTY_W-1:0]       duty_clamped;
   logic                              word_lit;

   assign duty_clamped = (duty_raw > 8'(dtpd_pkg::DUTY_MAX)) ?
                         dtpd_pkg::DUTY_W'(dtpd_pkg::DUTY_MAX) : duty_raw[6:0];

   // The current word is lit when it lies below round(duty * words / 100),
   // which reduces to 100 * index + 50 <= duty * words.
   assign word_lit = (CW'(index_ff) * CW'(100) + CW'(50))
                     <= (CW'(duty_ff) * CW'(WAVE_WORDS));

   always_comb begin
      logic [RW-1:0] repeats_dec;
      run_in      = run_ff;
      duty_in     = duty_ff;
      reload_in   = reload_ff;
      tick_in     = tick_ff;
      index_in    = index_ff;
      repeats_in  = repeats_ff;
      dma_idle_in = dma_idle_ff;
      pin_in      = pin_ff;
      rearm_in    = rearm_ff;
      repeats_dec = (repeats_ff != '0) ? (repeats_ff - 1'b1) : repeats_ff;
      if (push) begin
         unique case (req_kind)
            dtpd_pkg::REQ_TICK: begin
               if (run_ff == dtpd_pkg::STATUS_RUNNING) begin
                  if (tick_ff >= reload_ff) begin
                     tick_in = '0;
                     if (!dma_idle_ff) begin
                        pin_in = word_lit;
                        if (index_ff == IW'(WAVE_WORDS - 1)) begin
                           index_in   = '0;
                           repeats_in = repeats_dec;
                           if (repeats_dec == '0) begin
                              dma_idle_in = 1'b1;
                           end
                        end else begin
                           index_in = index_ff + 1'b1;
                        end
                     end
                  end else begin
                     tick_in = tick_ff + 1'b1;
                  end
               end
            end
            dtpd_pkg::REQ_START: begin
               tick_in  = '0;
               index_in = '0;
               if (clock_low) begin
                  pin_in      = 1'b0;
                  dma_idle_in = 1'b1;
                  repeats_in  = '0;
                  run_in      = dtpd_pkg::STATUS_REFUSED;
               end else begin
                  duty_in     = duty_clamped;
                  reload_in   = reload;
                  repeats_in  = RW'(BLOCK_REPEATS);
                  dma_idle_in = 1'b0;
                  run_in      = dtpd_pkg::STATUS_RUNNING;
               end
            end
            dtpd_pkg::REQ_DUTY: begin
               duty_in = duty_clamped;
            end
            dtpd_pkg::REQ_REARM: begin
               if (run_ff == dtpd_pkg::STATUS_RUNNING && dma_idle_ff) begin
                  index_in    = '0;
                  repeats_in  = RW'(BLOCK_REPEATS);
                  dma_idle_in = 1'b0;
                  rearm_in    = rearm_ff + 1'b1;
               end
            end
            dtpd_pkg::REQ_STOP: begin
               pin_in      = 1'b0;
               dma_idle_in = 1'b1;
               tick_in     = '0;
               index_in    = '0;
               repeats_in  = '0;
               run_in      = dtpd_pkg::STATUS_IDLE;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= dtpd_pkg::STATUS_IDLE;
         duty_ff     <= '0;
         reload_ff   <= '0;
         tick_ff     <= '0;
         index_ff    <= '0;
         repeats_ff  <= '0;
         dma_idle_ff <= 1'b1;
         pin_ff      <= 1'b0;
         rearm_ff    <= '0;
      end else begin
         run_ff      <= run_in;
         duty_ff     <= duty_in;
         reload_ff   <= reload_in;
         tick_ff     <= tick_in;
         index_ff    <= index_in;
         repeats_ff  <= repeats_in;
         dma_idle_ff <= dma_idle_in;
         pin_ff      <= pin_in;
         rearm_ff    <= rearm_in;
      end
   end

   // The response reflects the state after the request is applied.
   always_comb begin
      result.light_on      = pin_in;
      result.status_code   = run_in;
      result.word_position = dtpd_pkg::POS_W'(index_in);
      result.channel_idle  = dma_idle_in;
      result.rearm_total   = rearm_in;
   end

   a_index_in_table: assert property (@(posedge clock) disable iff (reset)
      index_ff <= IW'(WAVE_WORDS - 1))
      else $error("word index ran past the table");

   a_stopped_is_parked: assert property (@(posedge clock) disable iff (reset)
      run_ff != dtpd_pkg::STATUS_RUNNING |-> index_ff == '0 && dma_idle_ff)
      else $error("channel active while not running");

endmodule

// ===== src/dtpd_outbuf.sv =====
// ----------------------------------------------------------------------------
// Response buffer
// Two-entry output register with skid stage for the response channel.
// ----------------------------------------------------------------------------
module dtpd_outbuf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  dtpd_pkg::result_type  push_data,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output dtpd_pkg::result_type  out_data
);

   logic                  out_valid_ff, out_valid_in;
   logic                  skid_valid_ff, skid_valid_in;
   dtpd_pkg::result_type  out_data_ff, out_data_in;
   dtpd_pkg::result_type  skid_data_ff, skid_data_in;
   logic                  pop;

   assign pop = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         out_data_in   = skid_valid_ff ? skid_data_ff : push_data;
         out_valid_in  = skid_valid_ff || push;
         skid_valid_in = 1'b0;
      end else if (push) begin
         skid_data_in  = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held with an empty output register");

endmodule

// ===== src/dma_table_pwm_dimmer.sv =====
// ----------------------------------------------------------------------------
// Table-driven PWM backlight dimmer
// Timer-paced walk through a table of pin words with block repeats and rearm.
// ----------------------------------------------------------------------------
// Usage: every request transaction on the req_ channel is either one timer
// clock tick or a command (start, set duty, poll rearm, stop), selected by
// req_tuser. Each request produces exactly one response transaction on the
// rsp_ channel carrying the light level, run status, next word position,
// channel idle flag and rearm count after the request has been applied.
// The response is registered, and one request can be accepted every cycle
// unless rsp_ stalls or a reload runs, so ticks stream at full clock rate.
// The rsp_ side has an output register plus a skid entry; while the receiver
// stalls, one more request is still taken, then req_tready drops until the
// backlog drains. No response is dropped or duplicated.
// The csr_ port writes the period and timer clock registers. After reset and
// after every register write the reload unit recomputes the timer reload with
// one multiply and a reciprocal multiplication taken in three 16-bit slices,
// and req_tready stays low during that time. Reset is synchronous and returns
// all state to idle with the light off and the DMA channel idle.
// ----------------------------------------------------------------------------
module dma_table_pwm_dimmer #(
   parameter int WAVE_WORDS    = 100,
   parameter int BLOCK_REPEATS = 2048,
   parameter int MIN_CLOCK_KHZ = 100
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] duty_value
   input  logic [2:0]                        req_tuser,   // [2:0] req_type
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] light_on, [2:1] status_code, [9:3] word_position, [10] channel_idle,
   // [26:11] rearm_total, [31:27] zero
   output logic [31:0]                       rsp_tdata,
   // Configuration write port.
   input  logic                              csr_we,
   input  logic [dtpd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [dtpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                           calc_busy;
   logic                           clock_low;
   logic [dtpd_pkg::RELOAD_W-1:0]  reload;
   logic                           buf_ready;
   logic                           accept;
   dtpd_pkg::result_type           result;
   dtpd_pkg::result_type           rsp_data;

   // Requests are held off while the reload value is being recomputed.
   assign req_tready = buf_ready && !calc_busy;
   assign accept     = req_tvalid && req_tready;

   dtpd_reload #(
      .WAVE_WORDS    (WAVE_WORDS),
      .MIN_CLOCK_KHZ (MIN_CLOCK_KHZ)
   ) u_reload (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (calc_busy),
      .clock_low (clock_low),
      .reload    (reload)
   );

   dtpd_engine #(
      .WAVE_WORDS    (WAVE_WORDS),
      .BLOCK_REPEATS (BLOCK_REPEATS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .req_kind  (req_tuser),
      .duty_raw  (req_tdata),
      .reload    (reload),
      .clock_low (clock_low),
      .result    (result)
   );

   dtpd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .in_ready  (buf_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   // Pack the response fields, first field in the lowest bits.
   assign rsp_tdata = {5'd0, rsp_data.rearm_total, rsp_data.channel_idle,
                       rsp_data.word_position, rsp_data.status_code,
                       rsp_data.light_on};

   a_no_accept_while_calc: assert property (@(posedge clock) disable iff (reset)
      calc_busy |-> !req_tready)
      else $error("request accepted while the reload value is stale");

endmodule
